[rtl/core/medd_pkg.sv]
`default_nettype none

package medd_pkg;

	localparam int VTX_W           = 32;
	localparam int NUM_BUCKETS_DEF = 256;
	localparam int BUCKET_WAYS_DEF = 4;

	localparam int CORNER_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [CORNER_W-1:0] CORNER_TRI  = 3'd3;
	localparam logic [CORNER_W-1:0] CORNER_QUAD = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_CORNER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMPLICIT     = 2'd1;

	localparam logic STATUS_NEW  = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Request to the bucket reduction unit.
	typedef struct packed {
		logic             start;
		logic [VTX_W-1:0] sum;
	} hash_req_t;

	typedef struct packed {
		logic [VTX_W-1:0] edge_start;
		logic [VTX_W-1:0] edge_end;
		logic             status;
	} edge_res_t;

endpackage

`default_nettype wire

[rtl/core/medd_ram.sv]
`default_nettype none

module medd_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/medd_bucket_mod.sv]
`default_nettype none

module medd_bucket_mod
	import medd_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hash_req_t        req,
	output logic                  done,
	output logic      [BKT_W-1:0] bucket
);

	localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

	generate
		if (IS_POW2) begin : g_mask
			localparam logic [BKT_W-1:0] MASK = BKT_W'(NUM_BUCKETS - 1);

			logic             done_q;
			logic [BKT_W-1:0] bucket_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= req.start;
				end
			end

			always_ff @(posedge clk) begin
				if (req.start) begin
					bucket_q <= BKT_W'(req.sum) & MASK;
				end
			end

			assign done   = done_q;
			assign bucket = bucket_q;
		end else begin : g_serial
			// Restoring reduction, four bits of the sum per cycle.
			localparam int REM_W  = BKT_W + 1;
			localparam int DIGITS = 4;
			localparam int STEPS  = VTX_W / DIGITS;
			localparam int CNT_W  = $clog2(STEPS);
			localparam logic [REM_W-1:0] MODV = REM_W'(NUM_BUCKETS);

			logic             busy_q;
			logic             done_q;
			logic [CNT_W-1:0] cnt_q;
			logic [VTX_W-1:0] sum_q;
			logic [REM_W-1:0] rem_q;
			logic [REM_W-1:0] rem_nx;

			always_comb begin
				rem_nx = rem_q;
				for (int i = 0; i < DIGITS; i++) begin
					rem_nx = {rem_nx[REM_W-2:0], sum_q[VTX_W-1-i]};
					if (rem_nx >= MODV) begin
						rem_nx = rem_nx - MODV;
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= 1'b0;
					if (req.start) begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end else if (busy_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(STEPS - 1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (req.start) begin
					sum_q <= req.sum;
					rem_q <= '0;
				end else if (busy_q) begin
					sum_q <= sum_q << DIGITS;
					rem_q <= rem_nx;
				end
			end

			assign done   = done_q;
			assign bucket = rem_q[BKT_W-1:0];
		end
	endgenerate

endmodule

`default_nettype wire

[rtl/core/mesh_edge_dedup.sv]
// Channel  Direction  Ready rule            Contents
// s_*      in         high in idle only     tdata: corner_a..corner_d, 32 bits each
// m_*      out        register, one deep    tdata: edge_start, edge_end; tuser: status;
//                                           tlast: last_of_polygon
// cfg_*    in         always ready          cfg_index: register, cfg_data: value
//
// After reset a clearing pass over all NUM_BUCKETS buckets zeroes their fill counts;
// no polygon is taken until it ends.
// Each edge goes through a setup state, the bucket reduction (a mask when NUM_BUCKETS is
// a power of two, else a serial restoring reduction), probes of the bucket's ways on the
// edge memory port and, unless the edge is already stored, a result state; a polygon
// adds an accept and a flush state.
// A result is held back one step so tlast can mark the polygon's final result; the
// sequencer stalls only when both the held result and the output register are full.
`default_nettype none

module mesh_edge_dedup
	import medd_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int BUCKET_WAYS = BUCKET_WAYS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [4*VTX_W-1:0]    s_tdata,   // corner_a, corner_b, corner_c, corner_d
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [2*VTX_W-1:0]    m_tdata,   // edge_start, edge_end
	output logic      [0:0]            m_tuser,   // status
	output logic                       m_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int DEPTH  = NUM_BUCKETS * BUCKET_WAYS;
	localparam int EADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(BUCKET_WAYS + 1);
	localparam logic [EADR_W-1:0] WAYS_E = EADR_W'(BUCKET_WAYS);
	localparam logic [FILL_W-1:0] WAYS_F = FILL_W'(BUCKET_WAYS);
	localparam logic [BKT_W-1:0]  LAST_BKT = BKT_W'(NUM_BUCKETS - 1);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_EDGE  = 7'b0000100,
		S_HASH  = 7'b0001000,
		S_LOOK  = 7'b0010000,
		S_RES   = 7'b0100000,
		S_FLUSH = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [CORNER_W-1:0] corner_count_q;
	logic                implicit_q;
	logic [VTX_W-1:0]    poly_cnt_q;
	logic [VTX_W-1:0]    v_q [4];
	logic                quad_q;
	logic [1:0]          k_q;
	logic [VTX_W-1:0]    a_q;
	logic [VTX_W-1:0]    b_q;
	logic [BKT_W-1:0]    bucket_q;
	logic [FILL_W-1:0]   way_q;
	logic                status_q;
	logic                pend_valid_q;
	edge_res_t           pend_q;
	logic                m_tvalid_q;
	edge_res_t           out_q;
	logic                out_last_q;
	logic [BKT_W-1:0]    clr_q;

	logic             s_acc;
	logic             quad_cfg;
	logic [VTX_W-1:0] impl_base;
	logic [1:0]       last_k;
	logic [1:0]       next_k;
	hash_req_t        hreq;
	logic             hdone;
	logic [BKT_W-1:0] hbucket;
	logic             out_free;
	logic             push;
	logic             push_last;
	logic             advance;
	logic [EADR_W-1:0] base;
	logic             hit;
	logic             miss_end;
	logic [VTX_W-1:0] x_rd;
	logic [VTX_W-1:0] y_rd;

	logic              fill_we;
	logic [BKT_W-1:0]  fill_waddr;
	logic [FILL_W-1:0] fill_wdata;
	logic              fill_re;
	logic [FILL_W-1:0] fill_rdata;
	logic              edge_we;
	logic [EADR_W-1:0] edge_waddr;
	logic              edge_re;
	logic [EADR_W-1:0] edge_raddr;
	logic [2*VTX_W-1:0] edge_rdata;

	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;
	assign quad_cfg  = (corner_count_q == CORNER_QUAD);
	assign impl_base = quad_cfg ? (poly_cnt_q << 2) : ((poly_cnt_q << 1) + poly_cnt_q);
	assign last_k    = quad_q ? 2'd3 : 2'd2;
	assign next_k    = (k_q == last_k) ? 2'd0 : k_q + 2'd1;

	assign hreq.start = (state_q == S_EDGE);
	assign hreq.sum   = v_q[k_q] + v_q[next_k];

	medd_bucket_mod #(
		.NUM_BUCKETS (NUM_BUCKETS)
	) u_bucket (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.done   (hdone),
		.bucket (hbucket)
	);

	assign base = EADR_W'(bucket_q) * WAYS_E;
	assign x_rd = edge_rdata[VTX_W-1:0];
	assign y_rd = edge_rdata[2*VTX_W-1:VTX_W];
	assign miss_end = (way_q == fill_rdata);
	assign hit = !miss_end &&
		(((x_rd == a_q) && (y_rd == b_q)) || ((x_rd == b_q) && (y_rd == a_q)));

	assign out_free  = !m_tvalid_q || m_tready;
	assign push      = ((state_q == S_RES) || (state_q == S_FLUSH)) && pend_valid_q && out_free;
	assign push_last = (state_q == S_FLUSH);
	assign advance   = ((state_q == S_LOOK) && hit) ||
		((state_q == S_RES) && (!pend_valid_q || out_free));

	// Fill counts per bucket; ways are always taken from way 0 upward.
	assign fill_we    = (state_q == S_CLEAR) ||
		((state_q == S_LOOK) && miss_end && (fill_rdata < WAYS_F));
	assign fill_waddr = (state_q == S_CLEAR) ? clr_q : bucket_q;
	assign fill_wdata = (state_q == S_CLEAR) ? '0 : FILL_W'(fill_rdata + 1'b1);
	assign fill_re    = (state_q == S_HASH) && hdone;

	assign edge_we    = (state_q == S_LOOK) && miss_end && (fill_rdata < WAYS_F);
	assign edge_waddr = base + EADR_W'(fill_rdata);
	assign edge_re    = ((state_q == S_HASH) && hdone) ||
		((state_q == S_LOOK) && !miss_end && !hit && (FILL_W'(way_q + 1'b1) < fill_rdata));
	assign edge_raddr = (state_q == S_HASH) ? EADR_W'(hbucket) * WAYS_E
		: base + EADR_W'(way_q) + EADR_W'(1);

	medd_ram #(
		.WIDTH (FILL_W),
		.DEPTH (NUM_BUCKETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (fill_re),
		.raddr (hbucket),
		.rdata (fill_rdata)
	);

	medd_ram #(
		.WIDTH (2*VTX_W),
		.DEPTH (DEPTH)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata ({b_q, a_q}),
		.re    (edge_re),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			corner_count_q <= CORNER_TRI;
			implicit_q     <= 1'b0;
			poly_cnt_q     <= '0;
			k_q            <= '0;
			way_q          <= '0;
			pend_valid_q   <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CORNER_COUNT: corner_count_q <= cfg_data;
					CFG_IMPLICIT:     implicit_q     <= cfg_data[0];
					default:          ;
				endcase
			end

			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_BKT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_acc) begin
						poly_cnt_q <= poly_cnt_q + 1'b1;
						k_q        <= '0;
						state_q    <= S_EDGE;
					end
				end
				S_EDGE: begin
					state_q <= S_HASH;
				end
				S_HASH: begin
					if (hdone) begin
						way_q   <= '0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (miss_end) begin
						state_q <= S_RES;
					end else if (!hit) begin
						way_q <= way_q + 1'b1;
					end
				end
				S_RES: begin
					if (advance) begin
						pend_valid_q <= 1'b1;
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (advance) begin
				if (k_q == last_k) begin
					state_q <= S_FLUSH;
				end else begin
					k_q     <= k_q + 2'd1;
					state_q <= S_EDGE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			quad_q <= quad_cfg;
			for (int i = 0; i < 4; i++) begin
				v_q[i] <= implicit_q ? impl_base + VTX_W'(i) : s_tdata[i*VTX_W +: VTX_W];
			end
		end
		if (state_q == S_EDGE) begin
			a_q <= v_q[k_q];
			b_q <= v_q[next_k];
		end
		if ((state_q == S_HASH) && hdone) begin
			bucket_q <= hbucket;
		end
		if ((state_q == S_LOOK) && miss_end) begin
			status_q <= (fill_rdata < WAYS_F) ? STATUS_NEW : STATUS_FULL;
		end
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= push_last;
		end
		if ((state_q == S_RES) && advance) begin
			pend_q.edge_start <= a_q;
			pend_q.edge_end   <= b_q;
			pend_q.status     <= status_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {out_q.edge_end, out_q.edge_start};
	assign m_tuser[0] = out_q.status;
	assign m_tlast    = out_last_q;

`ifndef SYNTHESIS
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("held result left over in idle");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("output register overwritten");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> (fill_wdata <= WAYS_F))
		else $error("bucket fill count past way count");

	a_edge_write: assert property (@(posedge clk) disable iff (!arst_n)
		edge_we |-> (fill_we && (state_q == S_LOOK)))
		else $error("edge stored without fill update");

	a_look_from_hash: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_HASH) && hdone) |=> (state_q == S_LOOK) && (way_q == '0))
		else $error("probe did not start at way zero");
`endif

endmodule

`default_nettype wire
